// File: hdl/oam_dma_pkg.sv
// Package with the item types, codes and helper functions of the object-memory DMA engine.
package oam_dma_pkg;

  // Item kind codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Startup sequencer phase codes.
  localparam logic [1:0] PHASE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_WRITTEN  = 2'd1;
  localparam logic [1:0] PHASE_STARTING = 2'd2;

  // Address constants.
  localparam logic [15:0] OAM_BASE   = 16'hFE00;
  localparam logic [7:0]  HIGH_PAGE  = 8'hFE;
  localparam logic [7:0]  PAGE_LOWER = 8'h20;

  // Default number of bytes moved by one transfer.
  localparam int TRANSFER_LENGTH_DEF = 160;

  // Bus region codes; addresses from 0xFE00 up belong to no region.
  localparam logic [2:0] REGION_NONE = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [15:0] effective_address;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic        dma_busy;
  } out_t;

  // Returns the bus region that holds an address.
  function automatic logic [2:0] region_of(input logic [15:0] addr);
    logic [2:0] r;
    if (addr < 16'h4000) begin
      r = 3'd0;
    end else if (addr < 16'h8000) begin
      r = 3'd1;
    end else if (addr < 16'hA000) begin
      r = 3'd2;
    end else if (addr < 16'hC000) begin
      r = 3'd3;
    end else if (addr < 16'hE000) begin
      r = 3'd4;
    end else if (addr < 16'hFE00) begin
      r = 3'd5;
    end else begin
      r = REGION_NONE;
    end
    return r;
  endfunction

  // True when both addresses lie in the same bus region.
  function automatic logic same_region(input logic [15:0] a, input logic [15:0] b);
    logic [2:0] ra;
    logic [2:0] rb;
    ra = region_of(a);
    rb = region_of(b);
    return (ra == rb) && (ra != REGION_NONE);
  endfunction

endpackage

// File: hdl/oam_dma_in_reg.sv
// Input register stage of the object-memory DMA engine.
module oam_dma_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  oam_dma_pkg::in_t   in_data_i,
  output logic               item_valid_o,
  input  logic               item_take_i,
  output oam_dma_pkg::in_t   item_o
);
  import oam_dma_pkg::*;

  logic valid_q;
  logic valid_d;
  in_t  data_q;
  logic load;

  // The register takes a new transfer when empty or when its item moves on.
  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// File: hdl/oam_dma_seq.sv
// DMA state, startup sequencer, conflict redirection and result register.
module oam_dma_seq #(
  parameter int TRANSFER_LENGTH = oam_dma_pkg::TRANSFER_LENGTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  oam_dma_pkg::in_t   item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output oam_dma_pkg::out_t  out_data_o
);
  import oam_dma_pkg::*;

  localparam int CW = $clog2(TRANSFER_LENGTH + 1);

  logic [1:0]    phase_q, phase_d;
  logic [7:0]    page_q, page_d;
  logic [15:0]   base_q, base_d;
  logic [CW-1:0] count_q, count_d;
  logic          busy_q, busy_d;
  logic          out_valid_q, out_valid_d;
  out_t          res;
  out_t          out_q;
  logic [15:0]   cur_addr;
  logic [7:0]    lowered_page;

  // The item moves on whenever the result register is free or being emptied.
  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);

  assign cur_addr     = base_q + 16'(count_q);
  assign lowered_page = (page_q >= HIGH_PAGE) ? (page_q - PAGE_LOWER) : page_q;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_d = phase_q;
    page_d  = page_q;
    base_d  = base_q;
    count_d = count_q;
    busy_d  = busy_q;
    res     = '0;
    case (item_i.func)
      FUNC_TICK: begin
        if (busy_q) begin
          res.copy_valid  = 1'b1;
          res.copy_source = cur_addr;
          res.copy_dest   = OAM_BASE + 16'(count_q);
          count_d         = count_q + CW'(1);
          if (count_d >= CW'(TRANSFER_LENGTH)) begin
            busy_d = 1'b0;
          end
        end
        case (phase_q)
          PHASE_WRITTEN: begin
            phase_d = PHASE_STARTING;
          end
          PHASE_STARTING: begin
            base_d  = {lowered_page, 8'h00};
            count_d = '0;
            busy_d  = 1'b1;
            phase_d = PHASE_IDLE;
          end
          default: begin
            phase_d = PHASE_IDLE;
          end
        endcase
      end
      FUNC_WRITE: begin
        page_d  = item_i.write_data;
        phase_d = PHASE_WRITTEN;
      end
      FUNC_READ: begin
        res.effective_address = item_i.address;
        if (busy_q && same_region(item_i.address, base_q)) begin
          res.effective_address = cur_addr;
        end
      end
      default: begin
      end
    endcase
    res.dma_busy = busy_d;
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PHASE_IDLE;
      page_q      <= '0;
      base_q      <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (item_take_o) begin
        phase_q <= phase_d;
        page_q  <= page_d;
        base_q  <= base_d;
        count_q <= count_d;
        busy_q  <= busy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/oam_dma_engine_top.sv
// Top level of the object-memory DMA engine.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    in_data_i  (oam_dma_pkg::in_t)
//   out       output     out_valid_o / out_ready_i  out_data_o (oam_dma_pkg::out_t)
//
// An item passes from the input register to the result register, which then offers its
// result on the out channel. One item is taken every cycle while the output does not
// stall. The DMA state is updated as each item moves between the two registers. Reset
// clears the DMA state and both valid flags. When the output stalls, the result register
// holds and the input register fills, then in_ready_o drops.
module oam_dma_engine_top #(
  parameter int TRANSFER_LENGTH = oam_dma_pkg::TRANSFER_LENGTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  oam_dma_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output oam_dma_pkg::out_t  out_data_o
);
  import oam_dma_pkg::*;

  logic item_valid;
  logic item_take;
  in_t  item;

  oam_dma_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  oam_dma_seq #(
    .TRANSFER_LENGTH (TRANSFER_LENGTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // A copy always lands in object memory.
  a_copy_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.copy_valid) |-> (out_data_o.copy_dest[15:8] == 8'hFE))
    else $error("copy destination outside object memory");

  // A copy result never carries a read address.
  a_copy_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.copy_valid) |-> (out_data_o.effective_address == 16'h0000))
    else $error("copy result with a read address");

  // The input side stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && item_valid))
    else $error("input stalled without an output stall");

  // A held item moves on at once when the result register is free.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && !out_valid_o) |=> out_valid_o)
    else $error("item not moved to the result register");

endmodule

// File: tb/oam_dma_engine_top_tb.sv
// Self-checking testbench for the object-memory DMA engine top level.
`timescale 1ns / 100ps

module oam_dma_engine_top_tb;
  import oam_dma_pkg::*;

  localparam int          TRANSFER_LENGTH = TRANSFER_LENGTH_DEF;
  localparam logic [1:0]  FUNC_UNUSED     = 2'd3;
  localparam int          STALL_CYCLES    = 80;
  localparam int          WATCHDOG_LIMIT  = 1000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  // Mirror of the engine state, advanced once per accepted item.
  logic [7:0]  dma_page    = 8'h00;
  logic [1:0]  dma_phase   = PHASE_IDLE;
  logic [15:0] dma_base    = 16'h0000;
  int          dma_count   = 0;
  logic        dma_running = 1'b0;

  out_t expected_results[$];
  int   errors         = 0;
  bit   idle_en        = 1'b1;
  int   stall_requests = 0;
  int   quiet_cycles   = 0;

  oam_dma_engine_top #(
    .TRANSFER_LENGTH(TRANSFER_LENGTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bus region index of an address; -1 for the object memory and I/O area.
  function automatic int bus_region(input logic [15:0] addr);
    if (addr < 16'h4000) return 0;
    if (addr < 16'h8000) return 1;
    if (addr < 16'hA000) return 2;
    if (addr < 16'hC000) return 3;
    if (addr < 16'hE000) return 4;
    if (addr < 16'hFE00) return 5;
    return -1;
  endfunction

  // Computes the result of one item and advances the mirrored state.
  function automatic out_t predict_dma_step(input in_t item);
    out_t       res;
    logic [7:0] page;
    int         region;
    res = '0;
    case (item.func)
      FUNC_TICK: begin
        // The copy of this tick comes before any startup step.
        if (dma_running) begin
          res.copy_valid  = 1'b1;
          res.copy_source = dma_base + 16'(dma_count);
          res.copy_dest   = OAM_BASE + 16'(dma_count);
          dma_count++;
          if (dma_count >= TRANSFER_LENGTH) dma_running = 1'b0;
        end
        if (dma_phase == PHASE_WRITTEN) begin
          dma_phase = PHASE_STARTING;
        end else if (dma_phase == PHASE_STARTING) begin
          page = dma_page;
          if (page >= HIGH_PAGE) page = page - PAGE_LOWER;
          dma_base    = {page, 8'h00};
          dma_count   = 0;
          dma_running = 1'b1;
          dma_phase   = PHASE_IDLE;
        end else begin
          dma_phase = PHASE_IDLE;
        end
      end
      FUNC_WRITE: begin
        dma_page  = item.write_data;
        dma_phase = PHASE_WRITTEN;
      end
      FUNC_READ: begin
        // A read on the bus that the transfer occupies sees the current copy address.
        res.effective_address = item.address;
        region = bus_region(item.address);
        if (dma_running && region >= 0 && region == bus_region(dma_base)) begin
          res.effective_address = dma_base + 16'(dma_count);
        end
      end
      default: begin
      end
    endcase
    res.dma_busy = dma_running;
    return res;
  endfunction

  function automatic in_t make_item(input logic [1:0] func, input logic [15:0] addr,
                                    input logic [7:0] data);
    in_t item;
    item.func       = func;
    item.address    = addr;
    item.write_data = data;
    return item;
  endfunction

  // Read address: anywhere, near the current source, or at a region boundary.
  function automatic logic [15:0] pick_address();
    logic [15:0] edge_addr;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 16'($urandom_range(0, 65535));
    if (roll < 80) return dma_base + 16'($urandom_range(0, 16'h1FFF)) - 16'h0100;
    case ($urandom_range(0, 6))
      0:       edge_addr = 16'h4000;
      1:       edge_addr = 16'h8000;
      2:       edge_addr = 16'hA000;
      3:       edge_addr = 16'hC000;
      4:       edge_addr = 16'hE000;
      5:       edge_addr = 16'hFE00;
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    return edge_addr - 16'($urandom_range(0, 1));
  endfunction

  // Random item; reads take what is left after ticks, writes and a few unused codes.
  function automatic in_t random_item(input int tick_pct, input int write_pct);
    in_t item;
    int  roll;
    item.address    = 16'($urandom_range(0, 65535));
    item.write_data = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      item.func = FUNC_TICK;
    end else if (roll < tick_pct + write_pct) begin
      item.func = FUNC_WRITE;
    end else if (roll < 96) begin
      item.func    = FUNC_READ;
      item.address = pick_address();
    end else begin
      item.func = FUNC_UNUSED;
    end
    return item;
  endfunction

  // Offers one item, waits for its transfer and records the expected result.
  task automatic send_item(input in_t item);
    while (idle_en && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_dma_step(item));
  endtask

  // Extremes of the page, region edges, unused code and a write during a transfer.
  task automatic test_directed_cases();
    send_item(make_item(FUNC_READ,   16'h0000, 8'h00));
    send_item(make_item(FUNC_UNUSED, 16'hFFFF, 8'hFF));
    send_item(make_item(FUNC_TICK,   16'hFFFF, 8'hFF));
    send_item(make_item(FUNC_WRITE,  16'h0000, 8'hFF));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_READ,   16'hDF00, 8'h00));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_READ,   16'hC000, 8'h00));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_READ,   16'hFE00, 8'h00));
    send_item(make_item(FUNC_READ,   16'hE000, 8'h00));
    send_item(make_item(FUNC_UNUSED, 16'h0000, 8'h00));
    send_item(make_item(FUNC_READ,   16'hDFFF, 8'h00));
    send_item(make_item(FUNC_WRITE,  16'hFFFF, 8'h00));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_READ,   16'h3FFF, 8'h00));
    send_item(make_item(FUNC_READ,   16'h4000, 8'h00));
    send_item(make_item(FUNC_WRITE,  16'h0000, 8'hFE));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_WRITE,  16'h0000, 8'hFD));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_TICK,   16'h0000, 8'h00));
    send_item(make_item(FUNC_READ,   16'hFD10, 8'h00));
    send_item(make_item(FUNC_READ,   16'hFFFF, 8'h00));
  endtask

  // Runs a transfer to its end; optionally restarts it on the very tick that ends it.
  task automatic test_full_transfer(input bit restart_on_end);
    bit restarted;
    restarted = 1'b0;
    send_item(make_item(FUNC_WRITE, 16'($urandom), 8'($urandom)));
    send_item(make_item(FUNC_TICK, 16'($urandom), 8'($urandom)));
    send_item(make_item(FUNC_TICK, 16'($urandom), 8'($urandom)));
    while (dma_running && !(restarted && dma_count >= 4)) begin
      if (restart_on_end && !restarted && dma_count == TRANSFER_LENGTH - 2) begin
        send_item(make_item(FUNC_WRITE, 16'($urandom), 8'($urandom)));
        restarted = 1'b1;
      end else begin
        send_item(random_item(72, 0));
      end
    end
  endtask

  // Free mix, including writes that land in the middle of transfers and startups.
  task automatic test_random_mix(input int count);
    repeat (count) send_item(random_item(55, 15));
  endtask

  // The receiver holds off while items keep coming, so the input side must stall.
  task automatic test_output_stall();
    stall_requests++;
    send_item(make_item(FUNC_WRITE, 16'($urandom), 8'($urandom)));
    repeat (40) send_item(random_item(60, 5));
  endtask

  // Stimulus and end of run.
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    idle_en = 1'b0;
    test_full_transfer(1'b0);
    idle_en = 1'b1;
    test_full_transfer(1'b1);
    test_random_mix(60);
    test_output_stall();

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int hold_cnt;
    int served;
    hold_cnt = 0;
    served   = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (served != stall_requests) begin
        served   = stall_requests;
        hold_cnt = STALL_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (idle_en) begin
        out_ready_i <= ($urandom_range(0, 99) >= 20);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compares every result transfer with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_data_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.effective_address !== want.effective_address) begin
          $display("%0t: effective_address expected %h actual %h", $realtime,
                   want.effective_address, out_data_o.effective_address);
          errors++;
        end
        if (out_data_o.copy_valid !== want.copy_valid) begin
          $display("%0t: copy_valid expected %b actual %b", $realtime,
                   want.copy_valid, out_data_o.copy_valid);
          errors++;
        end
        if (out_data_o.copy_source !== want.copy_source) begin
          $display("%0t: copy_source expected %h actual %h", $realtime,
                   want.copy_source, out_data_o.copy_source);
          errors++;
        end
        if (out_data_o.copy_dest !== want.copy_dest) begin
          $display("%0t: copy_dest expected %h actual %h", $realtime,
                   want.copy_dest, out_data_o.copy_dest);
          errors++;
        end
        if (out_data_o.dma_busy !== want.dma_busy) begin
          $display("%0t: dma_busy expected %b actual %b", $realtime,
                   want.dma_busy, out_data_o.dma_busy);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $realtime,
                 expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// File: oam_dma_engine_top.f
hdl/oam_dma_pkg.sv
hdl/oam_dma_in_reg.sv
hdl/oam_dma_seq.sv
hdl/oam_dma_engine_top.sv
tb/oam_dma_engine_top_tb.sv
